[src/psodu_pkg.sv]
`timescale 1ns / 1ps

package psodu_pkg;

  // fixed field widths and limits
  localparam int unsigned SUM_SHIFT = 28;
  localparam int unsigned SUM_W     = 51;
  localparam int unsigned NV_W      = SUM_W - SUM_SHIFT;
  localparam logic [15:0] POS_MAX   = 16'hFFFF;
  localparam logic [9:0]  DUR_MAX   = 10'd1023;

  // register reset values
  localparam logic [15:0] INERTIA_RST   = 16'd2867;
  localparam logic [15:0] COGNITIVE_RST = 16'd6144;
  localparam logic [15:0] SOCIAL_RST    = 16'd6144;
  localparam logic [7:0]  MIN_DUR_RST   = 8'd5;
  localparam logic [7:0]  MAX_DUR_RST   = 8'd59;

  // register index map
  typedef enum logic [2:0] {
    REG_INERTIA   = 3'd0,
    REG_COGNITIVE = 3'd1,
    REG_SOCIAL    = 3'd2,
    REG_MIN_DUR   = 3'd3,
    REG_MAX_DUR   = 3'd4
  } psodu_reg_e;

  typedef struct packed {
    logic [15:0]        position;
    logic signed [15:0] velocity;
    logic [15:0]        personal_best;
    logic [15:0]        global_best;
    logic [15:0]        rand_one;
    logic [15:0]        rand_two;
    logic               searched;
    logic [9:0]         fixed_duration;
  } psodu_in_t;

  typedef struct packed {
    logic [15:0]        new_position;
    logic signed [15:0] new_velocity;
    logic [9:0]         duration;
    logic               hit_bound;
  } psodu_out_t;

  typedef struct packed {
    logic [15:0] inertia_weight;
    logic [15:0] cognitive_gain;
    logic [15:0] social_gain;
    logic [7:0]  lower_bound;
    logic [7:0]  upper_bound;
  } psodu_cfg_t;

  // part of the word that rides along the pipeline untouched
  typedef struct packed {
    logic               valid;
    logic [15:0]        position;
    logic signed [15:0] velocity;
    logic               searched;
    logic [9:0]         fixed_duration;
  } psodu_ctx_t;

endpackage

[src/psodu_product.sv]
`timescale 1ns / 1ps

module psodu_product import psodu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  psodu_in_t              item_i,
  input  psodu_cfg_t             cfg_i,
  output psodu_ctx_t             ctx_o,
  output logic signed [NV_W-1:0] nv_o
);

  // stage a: gain products and best distances
  logic               a_valid_q;
  psodu_ctx_t         a_ctx_q;
  logic signed [32:0] a_wv_q, a_wv_d;
  logic [31:0]        a_c1r1_q, a_c2r2_q;
  logic signed [16:0] a_d1_q, a_d2_q;

  // stage b: distance products
  logic               b_valid_q;
  psodu_ctx_t         b_ctx_q;
  logic signed [32:0] b_wv_q;
  logic signed [48:0] b_p1_q, b_p1_d, b_p2_q, b_p2_d;

  // stage c: floored velocity
  logic                   c_valid_q;
  psodu_ctx_t             c_ctx_q;
  logic signed [SUM_W-1:0] c_sum_d;
  logic signed [NV_W-1:0] c_nv_q;

  assign a_wv_d = $signed({1'b0, cfg_i.inertia_weight}) * $signed(item_i.velocity);
  assign b_p1_d = $signed({1'b0, a_c1r1_q}) * a_d1_q;
  assign b_p2_d = $signed({1'b0, a_c2r2_q}) * a_d2_q;

  // exact sum at 28 extra fraction bits
  assign c_sum_d = $signed({{2{b_wv_q[32]}}, b_wv_q, 16'b0})
                 + $signed({{2{b_p1_q[48]}}, b_p1_q})
                 + $signed({{2{b_p2_q[48]}}, b_p2_q});

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    a_ctx_q.valid          <= 1'b0;
    a_ctx_q.position       <= item_i.position;
    a_ctx_q.velocity       <= item_i.velocity;
    a_ctx_q.searched       <= item_i.searched;
    a_ctx_q.fixed_duration <= item_i.fixed_duration;
    a_wv_q   <= a_wv_d;
    a_c1r1_q <= cfg_i.cognitive_gain * item_i.rand_one;
    a_c2r2_q <= cfg_i.social_gain * item_i.rand_two;
    a_d1_q   <= $signed({1'b0, item_i.personal_best}) - $signed({1'b0, item_i.position});
    a_d2_q   <= $signed({1'b0, item_i.global_best}) - $signed({1'b0, item_i.position});

    b_ctx_q <= a_ctx_q;
    b_wv_q  <= a_wv_q;
    b_p1_q  <= b_p1_d;
    b_p2_q  <= b_p2_d;

    c_ctx_q <= b_ctx_q;
    // arithmetic shift by taking the top bits floors toward minus infinity
    c_nv_q  <= c_sum_d[SUM_W-1:SUM_SHIFT];
  end

  always_comb begin
    ctx_o       = c_ctx_q;
    ctx_o.valid = c_valid_q;
  end

  assign nv_o = c_nv_q;

endmodule

[src/psodu_limit.sv]
`timescale 1ns / 1ps

module psodu_limit import psodu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  psodu_ctx_t             ctx_i,
  input  logic signed [NV_W-1:0] nv_i,
  input  psodu_cfg_t             cfg_i,
  output logic                   done_o,
  output psodu_out_t             result_o
);

  localparam int unsigned VW = 8 + FRAC_BITS;
  localparam int unsigned CW = ((NV_W > VW + 1) ? NV_W : VW + 1) + 1;
  localparam int unsigned XW = ((VW + 2) > 18) ? VW + 2 : 18;
  localparam int unsigned PW = (VW > 16) ? VW : 16;

  logic [7:0]    span;
  logic [VW-1:0] vlim;
  logic [VW-1:0] lo_full, hi_full;
  logic [PW-1:0] lo_ext, hi_ext;
  logic [15:0]   lo, hi;

  // bounds from configuration
  always_comb begin
    span    = cfg_i.upper_bound - cfg_i.lower_bound;
    vlim    = (cfg_i.upper_bound > cfg_i.lower_bound) ? {span, {FRAC_BITS{1'b0}}} : '0;
    lo_full = {cfg_i.lower_bound, {FRAC_BITS{1'b0}}};
    hi_full = {cfg_i.upper_bound, {FRAC_BITS{1'b0}}};
    lo_ext  = PW'(lo_full);
    hi_ext  = PW'(hi_full);
    lo      = (lo_ext > PW'(POS_MAX)) ? POS_MAX : lo_ext[15:0];
    hi      = (hi_ext > PW'(POS_MAX)) ? POS_MAX : hi_ext[15:0];
  end

  // stage d: velocity limit, position step, absorbing bounds
  logic               d_valid_q;
  psodu_ctx_t         d_ctx_q;
  logic [15:0]        d_nx_q, d_nx_d;
  logic signed [15:0] d_nv_q, d_nv_d;
  logic               d_hit_q, d_hit_d;

  always_comb begin
    logic signed [CW-1:0] nv_ext;
    logic signed [CW-1:0] lim;
    logic signed [CW-1:0] vc;
    logic signed [XW-1:0] nx;
    logic signed [XW-1:0] lo_s;
    logic signed [XW-1:0] hi_s;
    nv_ext = $signed({{(CW-NV_W){nv_i[NV_W-1]}}, nv_i});
    lim    = $signed({{(CW-VW){1'b0}}, vlim});
    vc     = nv_ext;
    if (vc > lim) begin
      vc = lim;
    end
    if (vc < -lim) begin
      vc = -lim;
    end
    if (vc > $signed(CW'(32767))) begin
      vc = $signed(CW'(32767));
    end
    if (vc < -$signed(CW'(32768))) begin
      vc = -$signed(CW'(32768));
    end
    d_nv_d  = vc[15:0];
    nx      = $signed({{(XW-16){vc[15]}}, vc[15:0]})
            + $signed({{(XW-16){1'b0}}, ctx_i.position});
    lo_s    = $signed({{(XW-16){1'b0}}, lo});
    hi_s    = $signed({{(XW-16){1'b0}}, hi});
    d_hit_d = 1'b0;
    // lower clamp first, so crossed bounds end at the upper one
    if (nx < lo_s) begin
      nx      = lo_s;
      d_nv_d  = '0;
      d_hit_d = 1'b1;
    end
    if (nx > hi_s) begin
      nx      = hi_s;
      d_nv_d  = '0;
      d_hit_d = 1'b1;
    end
    d_nx_d = nx[15:0];
  end

  // stage e: rounding and output select
  logic       e_valid_q;
  psodu_out_t e_res_q, e_res_d;

  always_comb begin
    logic [16:0] rsum;
    logic [16:0] rsh;
    rsum = {1'b0, d_nx_q} + (17'd1 << (FRAC_BITS - 1));
    rsh  = rsum >> FRAC_BITS;
    if (d_ctx_q.searched) begin
      e_res_d.new_position = d_nx_q;
      e_res_d.new_velocity = d_nv_q;
      e_res_d.duration     = (rsh > 17'(DUR_MAX)) ? DUR_MAX : rsh[9:0];
      e_res_d.hit_bound    = d_hit_q;
    end else begin
      e_res_d.new_position = d_ctx_q.position;
      e_res_d.new_velocity = d_ctx_q.velocity;
      e_res_d.duration     = d_ctx_q.fixed_duration;
      e_res_d.hit_bound    = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      d_valid_q <= ctx_i.valid;
      e_valid_q <= d_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    d_ctx_q <= ctx_i;
    d_nx_q  <= d_nx_d;
    d_nv_q  <= d_nv_d;
    d_hit_q <= d_hit_d;
    e_res_q <= e_res_d;
  end

  assign done_o   = e_valid_q;
  assign result_o = e_res_q;

endmodule

[src/pso_dimension_update.sv]
`timescale 1ns / 1ps
// per-dimension particle swarm velocity and position update
// pipeline: done_o rises once the word has passed two multiply stages, a sum
//   stage, a clamp stage and a rounding stage, the first loaded at the start edge
// throughput: one word per cycle, busy stays low and results cannot be held off
// reset: rst_ni clears all valid bits at once and loads the gain and bound defaults

module pso_dimension_update import psodu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  psodu_in_t   item_i,
  output logic        done_o,
  output psodu_out_t  result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  psodu_cfg_t cfg_q;
  psodu_ctx_t ctx;
  logic signed [NV_W-1:0] nv;

  // the pipeline advances every cycle
  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inertia_weight <= INERTIA_RST;
      cfg_q.cognitive_gain <= COGNITIVE_RST;
      cfg_q.social_gain    <= SOCIAL_RST;
      cfg_q.lower_bound    <= MIN_DUR_RST;
      cfg_q.upper_bound    <= MAX_DUR_RST;
    end else if (cfg_we_i) begin
      unique case (psodu_reg_e'(cfg_addr_i))
        REG_INERTIA:   cfg_q.inertia_weight <= cfg_wdata_i;
        REG_COGNITIVE: cfg_q.cognitive_gain <= cfg_wdata_i;
        REG_SOCIAL:    cfg_q.social_gain    <= cfg_wdata_i;
        REG_MIN_DUR:   cfg_q.lower_bound    <= cfg_wdata_i[7:0];
        REG_MAX_DUR:   cfg_q.upper_bound    <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  psodu_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .ctx_o   (ctx),
    .nv_o    (nv)
  );

  psodu_limit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_limit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctx_i    (ctx),
    .nv_i     (nv),
    .cfg_i    (cfg_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
